/* rtl/core/idcrc_pkg.sv */
// Shared types, constants and the byte-wide CRC-32 fold for the ID-to-serial block.
package idcrc_pkg;

  localparam logic [31:0] CRC_PRESET  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam int          CNT_W       = 4;
  localparam int          IDX_W       = 3;
  localparam logic [2:0]  IDX_FIRST   = 3'd0;
  localparam logic [2:0]  IDX_CHECK   = 3'd4;
  localparam int          QUEUE_DEPTH = 2;
  localparam int          QPTR_W      = 1;
  localparam int          QCNT_W      = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Reflected CRC-32, all eight bit steps of one byte.
  function automatic logic [31:0] crc_fold_byte(input logic [31:0] acc,
                                                input logic [7:0]  b);
    logic [31:0] a;
    int k;
    a = acc ^ {24'd0, b};
    for (k = 0; k < 8; k++) begin
      a = a[0] ? ((a >> 1) ^ CRC_POLY) : (a >> 1);
    end
    return a;
  endfunction

endpackage

/* rtl/core/idcrc_front.sv */
// Front end: takes ID bytes, folds them into the CRC, queues the word at ID end.
module idcrc_front #(
  parameter int ID_LEN = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_id_byte,
  input  idcrc_pkg::q_stat_t       q_stat,
  output logic                     push,
  output logic [31:0]              push_data
);
  import idcrc_pkg::*;

  logic [31:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cnt_inc;
  logic [31:0]      crc_fold;
  logic             accept;
  logic             done;

  assign in_ready  = !q_stat.full;
  assign accept    = in_valid && in_ready;
  assign crc_fold  = crc_fold_byte(crc_r, in_id_byte);
  assign cnt_inc   = cnt_r + CNT_W'(1);
  // count wraps at 4 bits; ">=" still closes the ID
  assign done      = cnt_inc >= CNT_W'(ID_LEN);
  assign push      = accept && done;
  assign push_data = crc_fold;

  always_comb begin
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (done) begin
        crc_nxt = CRC_PRESET;
        cnt_nxt = '0;
      end else begin
        crc_nxt = crc_fold;
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_PRESET;
      cnt_r <= '0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (crc_r == CRC_PRESET) && (cnt_r == '0))
    else $error("CRC state not restarted after ID end");
`endif

endmodule

/* rtl/core/idcrc_queue.sv */
// Two-entry queue of finished CRC words between front and back.
module idcrc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [31:0]         push_data,
  input  logic                pop,
  output logic [31:0]         pop_data,
  output idcrc_pkg::q_stat_t  q_stat
);
  import idcrc_pkg::*;

  logic [31:0]       word0_r, word1_r;
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign q_stat.empty = cnt_r == '0;
  assign pop_data     = rd_ptr_r ? word1_r : word0_r;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (wr_ptr_r) begin
        word1_r <= push_data;
      end else begin
        word0_r <= push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !pop)
    else $error("pop from empty queue");
`endif

endmodule

/* rtl/core/idcrc_back.sv */
// Back end: turns one CRC word into five serial bytes on the result channel.
module idcrc_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  idcrc_pkg::q_stat_t       q_stat,
  output logic                     pop,
  input  logic [31:0]              pop_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_serial_byte,
  output logic [idcrc_pkg::IDX_W-1:0] out_serial_index,
  output logic                     out_run_last
);
  import idcrc_pkg::*;

  logic             valid_r, valid_nxt;
  logic [31:0]      word_r, word_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             fire;
  logic             last;
  logic             free;
  logic [7:0]       check_byte;

  assign fire  = valid_r && out_ready;
  assign last  = idx_r == IDX_CHECK;
  assign free  = !valid_r || (fire && last);
  assign pop   = free && !q_stat.empty;

  assign check_byte       = word_r[7:0] ^ word_r[15:8] ^ word_r[23:16] ^ word_r[31:24];
  assign out_valid        = valid_r;
  assign out_serial_index = idx_r;
  assign out_run_last     = last;
  assign out_serial_byte  = last ? check_byte : word_r[{idx_r[1:0], 3'b000} +: 8];

  always_comb begin
    valid_nxt = valid_r;
    word_nxt  = word_r;
    idx_nxt   = idx_r;
    if (pop) begin
      valid_nxt = 1'b1;
      word_nxt  = pop_data;
      idx_nxt   = IDX_FIRST;
    end else if (fire) begin
      if (last) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= IDX_FIRST;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> idx_r <= IDX_CHECK)
    else $error("serial index out of range");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && last && q_stat.empty) |=> !valid_r)
    else $error("result still valid after run end with empty queue");
`endif

endmodule

/* rtl/core/id_to_serial_crc32.sv */
// Top level: device ID bytes in, CRC-32 based 5-byte serial number out.
// The last ID byte pushes its CRC word into the queue; the serializer loads it when free.
// Throughput: one ID byte per cycle unless the queue is full; five result items per ID at
//   one per cycle while out_ready is high, so 12-byte IDs are limited by the byte input.
// The 2-entry CRC word queue decouples the byte front end from the serializer.
// Reset (rst_n low, synchronous): CRC preset to all ones, byte count and queue cleared.
module id_to_serial_crc32 #(
  parameter int ID_BYTES = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_id_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_serial_byte,
  output logic [idcrc_pkg::IDX_W-1:0] out_serial_index,
  output logic                        out_run_last
);
  import idcrc_pkg::*;

  // ID length clamped to what the 4-bit byte count can hold
  localparam int ID_LEN = (ID_BYTES < 1) ? 1 : ((ID_BYTES > 15) ? 15 : ID_BYTES);

  q_stat_t     q_stat;
  logic        push;
  logic [31:0] push_data;
  logic        pop;
  logic [31:0] pop_data;

  // front: per-byte CRC fold, pushes the finished word at ID end
  idcrc_front #(
    .ID_LEN (ID_LEN)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_id_byte (in_id_byte),
    .q_stat     (q_stat),
    .push       (push),
    .push_data  (push_data)
  );

  // queue of finished CRC words
  idcrc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // back: five result items per word, check byte last
  idcrc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .pop              (pop),
    .pop_data         (pop_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_serial_byte  (out_serial_byte),
    .out_serial_index (out_serial_index),
    .out_run_last     (out_run_last)
  );

endmodule
